// ===== rtl/core/kms_pkg.sv =====
// Package for the keypad matrix scan and debounce unit.
// Holds matrix geometry, field widths, register indexes and shared structs.
// No dependencies.
package kms_pkg;

    localparam int KMS_ROWS       = 3;
    localparam int KMS_COLS       = 3;
    localparam int KMS_ROW_W      = 3;
    localparam int KMS_DRIVE_W    = 3;
    localparam int KMS_KEY_W      = 9;
    localparam int KMS_COL_IDX_W  = 2;
    localparam int KMS_SETTLE_W   = 16;
    localparam int KMS_DEBOUNCE_W = 8;
    localparam int KMS_CFG_DATA_W = 16;
    localparam int KMS_CFG_IDX_W  = 1;

    localparam logic [KMS_CFG_IDX_W-1:0] KMS_REG_SETTLE_TICKS   = 1'd0;
    localparam logic [KMS_CFG_IDX_W-1:0] KMS_REG_DEBOUNCE_COUNT = 1'd1;

    localparam logic [KMS_SETTLE_W-1:0]   KMS_SETTLE_RESET   = 16'd10;
    localparam logic [KMS_DEBOUNCE_W-1:0] KMS_DEBOUNCE_RESET = 8'd5;

    // scanner to debounce: one completed scan word
    typedef struct packed {
        logic                 done;
        logic [KMS_KEY_W-1:0] sample;
    } kms_scan_t;

    // one result item
    typedef struct packed {
        logic [KMS_DRIVE_W-1:0] column_drive;
        logic [KMS_KEY_W-1:0]   press_mask;
        logic                   scan_done;
    } kms_result_t;

endpackage

// ===== rtl/core/kms_scan.sv =====
// Column scanner: drives one column at a time, settles, samples rows.
// Depends on kms_pkg.
module kms_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick,
    input  logic [kms_pkg::KMS_ROW_W-1:0]    row_levels,
    input  logic [kms_pkg::KMS_SETTLE_W-1:0] settle_ticks,
    output logic [kms_pkg::KMS_DRIVE_W-1:0]  column_drive,
    output kms_pkg::kms_scan_t               scan
);
    import kms_pkg::*;

    logic [KMS_COL_IDX_W-1:0] column_index_reg, column_index_next;
    logic [KMS_SETTLE_W-1:0]  settle_counter_reg, settle_counter_next;
    logic [KMS_KEY_W-1:0]     scan_word_reg, scan_word_next;
    logic [KMS_KEY_W-1:0]     sampled;
    logic                     sample_now;
    logic                     last_col;

    always_comb begin
        column_drive = '1;
        for (int c = 0; c < KMS_DRIVE_W; c++) begin
            if (column_index_reg == KMS_COL_IDX_W'(c)) begin
                column_drive[c] = 1'b0;
            end
        end
    end

    always_comb begin
        sampled = scan_word_reg;
        for (int r = 0; r < KMS_ROWS; r++) begin
            for (int c = 0; c < KMS_COLS; c++) begin
                if (r < KMS_ROW_W && (r * KMS_COLS + c) < KMS_KEY_W) begin
                    if (column_index_reg == KMS_COL_IDX_W'(c) && !row_levels[r]) begin
                        sampled[r * KMS_COLS + c] = 1'b1;
                    end
                end
            end
        end
    end

    assign sample_now = (settle_counter_reg >= settle_ticks);
    // an index at or beyond the last column counts as the last one
    assign last_col   = ({1'b0, column_index_reg} >= (KMS_COL_IDX_W + 1)'(KMS_COLS - 1));

    always_comb begin
        column_index_next   = column_index_reg;
        settle_counter_next = settle_counter_reg;
        scan_word_next      = scan_word_reg;
        scan.done           = 1'b0;
        scan.sample         = sampled;
        if (!sample_now) begin
            settle_counter_next = settle_counter_reg + 1'b1;
        end else begin
            settle_counter_next = '0;
            if (last_col) begin
                scan.done         = 1'b1;
                scan_word_next    = '0;
                column_index_next = '0;
            end else begin
                scan_word_next    = sampled;
                column_index_next = column_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_index_reg   <= '0;
            settle_counter_reg <= '0;
            scan_word_reg      <= '0;
        end else if (tick) begin
            column_index_reg   <= column_index_next;
            settle_counter_reg <= settle_counter_next;
            scan_word_reg      <= scan_word_next;
        end
    end

endmodule

// ===== rtl/core/kms_debounce.sv =====
// Debouncer: compares finished scans with the stable word, reports presses once.
// Depends on kms_pkg.
module kms_debounce (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              tick,
    input  kms_pkg::kms_scan_t                scan,
    input  logic [kms_pkg::KMS_DEBOUNCE_W-1:0] debounce_count,
    output logic [kms_pkg::KMS_KEY_W-1:0]      press_mask
);
    import kms_pkg::*;

    logic [KMS_KEY_W-1:0]      stable_word_reg, stable_word_next;
    logic [KMS_DEBOUNCE_W-1:0] match_counter_reg, match_counter_next;
    logic                      press_latched_reg, press_latched_next;
    logic [KMS_DEBOUNCE_W-1:0] threshold;
    logic                      settled;

    assign threshold = (debounce_count == '0) ? '0 : debounce_count - 1'b1;
    assign settled   = (match_counter_next >= threshold);

    always_comb begin
        stable_word_next   = stable_word_reg;
        match_counter_next = match_counter_reg;
        if (scan.sample == stable_word_reg) begin
            // saturate at the debounce count
            if (match_counter_reg < debounce_count) begin
                match_counter_next = match_counter_reg + 1'b1;
            end
        end else begin
            stable_word_next   = scan.sample;
            match_counter_next = '0;
        end
    end

    always_comb begin
        press_latched_next = press_latched_reg;
        press_mask         = '0;
        if (!press_latched_reg && stable_word_next != '0 && settled) begin
            press_latched_next = 1'b1;
            press_mask         = stable_word_next;
        end else if (press_latched_reg && stable_word_next == '0 && settled) begin
            press_latched_next = 1'b0;
        end
        if (!scan.done) begin
            press_mask = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_word_reg   <= '0;
            match_counter_reg <= '0;
            press_latched_reg <= 1'b0;
        end else if (tick && scan.done) begin
            stable_word_reg   <= stable_word_next;
            match_counter_reg <= match_counter_next;
            press_latched_reg <= press_latched_next;
        end
    end

endmodule

// ===== rtl/core/kms_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on kms_pkg.
module kms_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  kms_pkg::kms_result_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kms_pkg::kms_result_t out_data
);
    import kms_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    kms_result_t out_data_reg;
    kms_result_t skid_data_reg;
    logic        in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            // output slot frees up: drain skid first
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= in_data;
            end
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/core/keypad_matrix_scan_debounce_unit.sv =====
// Keypad matrix scan and debounce unit, top level.
// Uses kms_pkg, kms_scan, kms_debounce and kms_out_buf.
//
// Usage:
//   Input channel (s_valid/s_ready/s_row_levels): one transfer per timebase
//   tick, carrying the raw row levels (low means pressed).
//   Result channel (m_valid/m_ready/m_*): one transfer per input transfer,
//   giving the column drive in effect on that tick, any newly accepted press
//   mask and the scan-done flag.
//   Config port (cfg_wr_en/cfg_index/cfg_wdata): index 0 settle ticks,
//   index 1 debounce count; write while the block is idle.
// Timing:
//   Results are registered in the output or, when stalled, skid register.
//   Throughput is one item per cycle while s_ready is high; the scan and
//   debounce update is a single pass of logic from state to result register.
// Reset:
//   aresetn (synchronous, active low) clears scan state, debounce state and
//   the result buffer, and loads settle ticks 10 and debounce count 5.
// Stall:
//   A two-entry result buffer holds results while m_ready is low; s_ready
//   drops only once both entries are full, and rises again as they drain.
module keypad_matrix_scan_debounce_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kms_pkg::KMS_ROW_W-1:0]       s_row_levels,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kms_pkg::KMS_DRIVE_W-1:0]     m_column_drive,
    output logic [kms_pkg::KMS_KEY_W-1:0]       m_press_mask,
    output logic                                m_scan_done,
    input  logic                                cfg_wr_en,
    input  logic [kms_pkg::KMS_CFG_IDX_W-1:0]   cfg_index,
    input  logic [kms_pkg::KMS_CFG_DATA_W-1:0]  cfg_wdata
);
    import kms_pkg::*;

    logic [KMS_SETTLE_W-1:0]   settle_ticks_reg;
    logic [KMS_DEBOUNCE_W-1:0] debounce_count_reg;
    logic                      tick;
    kms_scan_t                 scan;
    kms_result_t               result;
    kms_result_t               result_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg   <= KMS_SETTLE_RESET;
            debounce_count_reg <= KMS_DEBOUNCE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                KMS_REG_SETTLE_TICKS:   settle_ticks_reg   <= cfg_wdata;
                KMS_REG_DEBOUNCE_COUNT: debounce_count_reg <= cfg_wdata[KMS_DEBOUNCE_W-1:0];
                default: ;
            endcase
        end
    end

    assign tick = s_valid && s_ready;

    kms_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (tick),
        .row_levels   (s_row_levels),
        .settle_ticks (settle_ticks_reg),
        .column_drive (result.column_drive),
        .scan         (scan)
    );

    kms_debounce u_debounce (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (tick),
        .scan           (scan),
        .debounce_count (debounce_count_reg),
        .press_mask     (result.press_mask)
    );

    assign result.scan_done = scan.done;

    kms_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result_out)
    );

    assign m_column_drive = result_out.column_drive;
    assign m_press_mask   = result_out.press_mask;
    assign m_scan_done    = result_out.scan_done;

endmodule

// ===== rtl/core/kms_checker.sv =====
// Port-level checks for the keypad matrix scan and debounce unit.
// Depends on kms_pkg; bound to keypad_matrix_scan_debounce_unit.
module kms_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [kms_pkg::KMS_DRIVE_W-1:0] m_column_drive,
    input logic [kms_pkg::KMS_KEY_W-1:0]   m_press_mask,
    input logic                            m_scan_done
);
    import kms_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column_drive)
            && $stable(m_press_mask) && $stable(m_scan_done))
        else $error("stalled result changed");

    // presses are only reported when a scan completes
    a_press_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_press_mask != '0 |-> m_scan_done)
        else $error("press mask outside scan completion");

    // exactly one column is driven on every result
    a_one_column: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones(m_column_drive) == KMS_DRIVE_W - 1)
        else $error("column drive not one-cold");

    // buffer is empty after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not ready after reset");

endmodule

bind keypad_matrix_scan_debounce_unit kms_checker u_kms_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_column_drive (m_column_drive),
    .m_press_mask   (m_press_mask),
    .m_scan_done    (m_scan_done)
);
